// ----- rtl/core/ps2kc_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2kc_pkg
// Shared widths, codes and structs of the 8042-style PS/2 keyboard controller.
// ----------------------------------------------------------------------------
package ps2kc_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PUSH_MAX   = 3;
    localparam int PUSH_NW    = $clog2(PUSH_MAX + 1);

    // Field widths
    localparam int CMD_W     = 3;
    localparam int PORT_W    = 16;
    localparam int DATA_W    = 8;
    localparam int STAT_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_PORT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_PORT = 2'd1;

    // Configuration reset values
    localparam logic [PORT_W-1:0] DATA_PORT_RST   = 16'h0060;
    localparam logic [PORT_W-1:0] STATUS_PORT_RST = 16'h0064;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_BUS_READ      = 3'd0,
        CMD_BUS_WRITE     = 3'd1,
        CMD_SCAN_NEWEST   = 3'd2,
        CMD_SCAN_LOSSLESS = 3'd3,
        CMD_TAKE_IRQ      = 3'd4,
        CMD_TAKE_AUX      = 3'd5
    } cmd_t;

    // Controller commands (status port write)
    localparam logic [DATA_W-1:0] CC_READ_CFG   = 8'h20;
    localparam logic [DATA_W-1:0] CC_WRITE_CFG  = 8'h60;
    localparam logic [DATA_W-1:0] CC_SELF_TEST  = 8'hAA;
    localparam logic [DATA_W-1:0] CC_KBD_TEST   = 8'hAB;
    localparam logic [DATA_W-1:0] CC_AUX_TEST   = 8'hA9;
    localparam logic [DATA_W-1:0] CC_WRITE_AUX  = 8'hD4;

    // Keyboard device commands (data port write)
    localparam logic [DATA_W-1:0] DEV_RESET     = 8'hFF;
    localparam logic [DATA_W-1:0] DEV_READ_ID   = 8'hF2;
    localparam logic [DATA_W-1:0] DEV_SET_SCAN  = 8'hF0;
    localparam logic [DATA_W-1:0] DEV_ECHO      = 8'hEE;
    localparam logic [DATA_W-1:0] SCAN_QUERY    = 8'h00;

    // Response bytes
    localparam logic [DATA_W-1:0] RSP_ACK       = 8'hFA;
    localparam logic [DATA_W-1:0] RSP_BAT_OK    = 8'hAA;
    localparam logic [DATA_W-1:0] RSP_SELF_OK   = 8'h55;
    localparam logic [DATA_W-1:0] RSP_PORT_OK   = 8'h00;
    localparam logic [DATA_W-1:0] RSP_ID_LO     = 8'hAB;
    localparam logic [DATA_W-1:0] RSP_ID_HI     = 8'h83;
    localparam logic [DATA_W-1:0] RSP_SCAN_SET  = 8'h02;
    localparam logic [DATA_W-1:0] RSP_ECHO      = 8'hEE;

    // Status register bits
    localparam logic [DATA_W-1:0] STS_SYSTEM    = 8'h04;
    localparam logic [DATA_W-1:0] STS_OBF       = 8'h01;

    // One input word
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PORT_W-1:0] port;
        logic [DATA_W-1:0] data;
    } item_t;

    // One result word
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_ok;
        logic              accepted;
        logic              irq_pulse;
        logic              aux_flag;
        logic              byte_pending;
        logic              guest_initialized;
        logic [STAT_W-1:0] queued_total;
        logic [STAT_W-1:0] read_total;
        logic [STAT_W-1:0] dropped_total;
    } result_t;

    // FIFO operation requested by the decoder
    typedef struct packed {
        logic                             flush;
        logic                             pop;
        logic [PUSH_NW-1:0]               push_num;
        logic                             push_scan;
        logic [PUSH_MAX-1:0][DATA_W-1:0]  push_data;
    } fifo_op_t;

    // FIFO status seen by the decoder
    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic [FIFO_CW-1:0] count_next;
        logic [DATA_W-1:0]  head_byte;
        logic               head_scan;
    } fifo_stat_t;

endpackage

// ----- rtl/core/ps2kc_item_if.sv -----
// ----------------------------------------------------------------------------
// ps2kc_item_if
// Input channel: command, port and data with valid/ready.
// ----------------------------------------------------------------------------
interface ps2kc_item_if
    import ps2kc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] data;

    modport source (output valid, output command, output port, output data, input ready);
    modport sink   (input valid, input command, input port, input data, output ready);
endinterface

// ----- rtl/core/ps2kc_result_if.sv -----
// ----------------------------------------------------------------------------
// ps2kc_result_if
// Result channel: one result word per input word, with valid/ready.
// ----------------------------------------------------------------------------
interface ps2kc_result_if
    import ps2kc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              access_ok;
    logic              accepted;
    logic              irq_pulse;
    logic              aux_flag;
    logic              byte_pending;
    logic              guest_initialized;
    logic [STAT_W-1:0] queued_total;
    logic [STAT_W-1:0] read_total;
    logic [STAT_W-1:0] dropped_total;

    modport source (
        output valid, output read_data, output access_ok, output accepted,
        output irq_pulse, output aux_flag, output byte_pending,
        output guest_initialized, output queued_total, output read_total,
        output dropped_total, input ready
    );
    modport sink (
        input valid, input read_data, input access_ok, input accepted,
        input irq_pulse, input aux_flag, input byte_pending,
        input guest_initialized, input queued_total, input read_total,
        input dropped_total, output ready
    );
endinterface

// ----- rtl/core/ps2kc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ps2kc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ps2kc_cfg_if
    import ps2kc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PORT_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/ps2kc_fifo.sv -----
// ----------------------------------------------------------------------------
// ps2kc_fifo
// Tagged output byte FIFO: flush, one pop or up to three pushes per word.
// ----------------------------------------------------------------------------
module ps2kc_fifo
    import ps2kc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       apply,
    input  fifo_op_t   op,
    output fifo_stat_t stat
);

    localparam int SUM_W = FIFO_CW + 1;

    logic [DATA_W-1:0]  bytes_reg [FIFO_DEPTH];
    logic               scan_reg  [FIFO_DEPTH];
    logic [FIFO_AW-1:0] head_reg;
    logic [FIFO_AW-1:0] head_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    logic [FIFO_AW-1:0] base_head;
    logic [FIFO_CW-1:0] base_count;
    logic [PUSH_MAX-1:0]              wr_en;
    logic [PUSH_MAX-1:0][FIFO_AW-1:0] wr_slot;

    // Work out write slots, next head and next fill level
    always_comb
    begin
        logic [SUM_W-1:0] room;
        logic [SUM_W-1:0] sum;
        logic [FIFO_CW-1:0] n_ok;

        base_head  = op.flush ? '0 : head_reg;
        base_count = op.flush ? '0 : count_reg;
        n_ok       = '0;
        head_next  = base_head;
        for (int k = 0; k < PUSH_MAX; k++)
        begin
            room = SUM_W'(base_count) + SUM_W'(k);
            sum  = SUM_W'(base_head) + room;
            if (sum >= SUM_W'(FIFO_DEPTH))
            begin
                sum = sum - SUM_W'(FIFO_DEPTH);
            end
            wr_slot[k] = sum[FIFO_AW-1:0];
            wr_en[k]   = (PUSH_NW'(k) < op.push_num) && (room < SUM_W'(FIFO_DEPTH));
            if (wr_en[k])
            begin
                n_ok = n_ok + 1'b1;
            end
        end
        if (op.pop)
        begin
            head_next  = (SUM_W'(head_reg) + 1'b1 == SUM_W'(FIFO_DEPTH)) ? '0
                                                                         : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = base_count + n_ok;
        end
    end

    // Update head and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (apply)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Write pushed bytes and their tags
    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            for (int k = 0; k < PUSH_MAX; k++)
            begin
                if (wr_en[k])
                begin
                    bytes_reg[wr_slot[k]] <= op.push_data[k];
                    scan_reg[wr_slot[k]]  <= op.push_scan;
                end
            end
        end
    end

    assign stat.count      = count_reg;
    assign stat.count_next = count_next;
    assign stat.head_byte  = bytes_reg[head_reg];
    assign stat.head_scan  = scan_reg[head_reg];

endmodule

// ----- rtl/core/ps2kc_core.sv -----
// ----------------------------------------------------------------------------
// ps2kc_core
// Command decode, controller flags, interrupt edge count and statistics.
// ----------------------------------------------------------------------------
module ps2kc_core
    import ps2kc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  item_t             item,
    input  logic [PORT_W-1:0] data_addr,
    input  logic [PORT_W-1:0] status_addr,
    input  fifo_stat_t        fstat,
    output fifo_op_t          fop,
    output result_t           res
);

    logic [FIFO_CW-1:0] held_reg,    held_next;
    logic [FIFO_CW-1:0] pending_reg, pending_next;
    logic [DATA_W-1:0]  ctl_cfg_reg, ctl_cfg_next;
    logic               expect_cfg_reg, expect_cfg_next;
    logic               expect_param_reg, expect_param_next;
    logic               route_reg, route_next;
    logic               wrote_reg, wrote_next;
    logic [STAT_W-1:0]  queued_reg, queued_next;
    logic [STAT_W-1:0]  read_reg, read_next;
    logic [STAT_W-1:0]  dropped_reg, dropped_next;

    cmd_t cmd;
    assign cmd = cmd_t'(item.command);

    // Decode one word
    always_comb
    begin
        logic edge_pop;

        fop               = '0;
        res               = '0;
        edge_pop          = 1'b0;
        held_next         = held_reg;
        pending_next      = pending_reg;
        ctl_cfg_next      = ctl_cfg_reg;
        expect_cfg_next   = expect_cfg_reg;
        expect_param_next = expect_param_reg;
        route_next        = route_reg;
        wrote_next        = wrote_reg;
        queued_next       = queued_reg;
        read_next         = read_reg;
        dropped_next      = dropped_reg;

        case (cmd)
            CMD_BUS_READ:
            begin
                if (item.port == data_addr)
                begin
                    res.access_ok = 1'b1;
                    if (fstat.count != '0)
                    begin
                        fop.pop       = 1'b1;
                        res.read_data = fstat.head_byte;
                        if (fstat.head_scan)
                        begin
                            read_next = read_reg + 1'b1;
                            if (held_reg != '0)
                            begin
                                held_next = held_reg - 1'b1;
                            end
                        end
                        edge_pop = (fstat.count > FIFO_CW'(1));
                    end
                end
                else if (item.port == status_addr)
                begin
                    res.access_ok = 1'b1;
                    res.read_data = STS_SYSTEM | ((fstat.count != '0) ? STS_OBF : '0);
                end
            end
            CMD_BUS_WRITE:
            begin
                wrote_next = 1'b1;
                if (item.port == status_addr)
                begin
                    res.access_ok = 1'b1;
                    case (item.data)
                        CC_READ_CFG:
                        begin
                            fop.push_num     = PUSH_NW'(1);
                            fop.push_data[0] = ctl_cfg_reg;
                        end
                        CC_WRITE_CFG: expect_cfg_next = 1'b1;
                        CC_SELF_TEST:
                        begin
                            fop.push_num     = PUSH_NW'(1);
                            fop.push_data[0] = RSP_SELF_OK;
                        end
                        CC_KBD_TEST, CC_AUX_TEST:
                        begin
                            fop.push_num     = PUSH_NW'(1);
                            fop.push_data[0] = RSP_PORT_OK;
                        end
                        CC_WRITE_AUX: route_next = 1'b1;
                        default: ;
                    endcase
                end
                else if (item.port == data_addr)
                begin
                    res.access_ok = 1'b1;
                    if (expect_cfg_reg)
                    begin
                        ctl_cfg_next    = item.data;
                        expect_cfg_next = 1'b0;
                    end
                    else if (item.data == DEV_RESET)
                    begin
                        fop.push_num     = PUSH_NW'(2);
                        fop.push_data[0] = RSP_ACK;
                        fop.push_data[1] = RSP_BAT_OK;
                    end
                    else if (expect_param_reg)
                    begin
                        expect_param_next = 1'b0;
                        fop.push_data[0]  = RSP_ACK;
                        fop.push_data[1]  = RSP_SCAN_SET;
                        fop.push_num      = (item.data == SCAN_QUERY) ? PUSH_NW'(2)
                                                                      : PUSH_NW'(1);
                    end
                    else if (item.data == DEV_READ_ID)
                    begin
                        fop.push_num     = PUSH_NW'(3);
                        fop.push_data[0] = RSP_ACK;
                        fop.push_data[1] = RSP_ID_LO;
                        fop.push_data[2] = RSP_ID_HI;
                    end
                    else if (item.data == DEV_SET_SCAN)
                    begin
                        expect_param_next = 1'b1;
                        fop.push_num      = PUSH_NW'(1);
                        fop.push_data[0]  = RSP_ACK;
                    end
                    else if (item.data == DEV_ECHO)
                    begin
                        fop.push_num     = PUSH_NW'(1);
                        fop.push_data[0] = RSP_ECHO;
                    end
                    else
                    begin
                        fop.push_num     = PUSH_NW'(1);
                        fop.push_data[0] = RSP_ACK;
                    end
                end
            end
            CMD_SCAN_NEWEST:
            begin
                // drop everything held, then queue the new scancode alone
                dropped_next     = dropped_reg + STAT_W'(held_reg);
                fop.flush        = 1'b1;
                fop.push_num     = PUSH_NW'(1);
                fop.push_scan    = 1'b1;
                fop.push_data[0] = item.data;
                held_next        = FIFO_CW'(1);
                queued_next      = queued_reg + 1'b1;
            end
            CMD_SCAN_LOSSLESS:
            begin
                if (fstat.count >= FIFO_CW'(FIFO_DEPTH))
                begin
                    dropped_next = dropped_reg + 1'b1;
                end
                else
                begin
                    fop.push_num     = PUSH_NW'(1);
                    fop.push_scan    = 1'b1;
                    fop.push_data[0] = item.data;
                    held_next        = held_reg + 1'b1;
                    queued_next      = queued_reg + 1'b1;
                    res.accepted     = 1'b1;
                end
            end
            CMD_TAKE_IRQ:
            begin
                if (pending_reg != '0)
                begin
                    pending_next  = pending_reg - 1'b1;
                    res.irq_pulse = 1'b1;
                end
            end
            CMD_TAKE_AUX:
            begin
                res.aux_flag = route_reg;
                route_next   = 1'b0;
            end
            default: ;
        endcase

        // count a new readable head, saturating at the FIFO depth
        if ((edge_pop || ((fop.flush || fstat.count == '0) && fop.push_num != '0))
            && pending_reg < FIFO_CW'(FIFO_DEPTH))
        begin
            pending_next = pending_reg + 1'b1;
        end

        res.byte_pending      = (fstat.count_next != '0);
        res.guest_initialized = wrote_next;
        res.queued_total      = queued_next;
        res.read_total        = read_next;
        res.dropped_total     = dropped_next;
    end

    // Commit state when the word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            pending_reg      <= '0;
            ctl_cfg_reg      <= '0;
            expect_cfg_reg   <= 1'b0;
            expect_param_reg <= 1'b0;
            route_reg        <= 1'b0;
            wrote_reg        <= 1'b0;
            queued_reg       <= '0;
            read_reg         <= '0;
            dropped_reg      <= '0;
        end
        else if (fire)
        begin
            held_reg         <= held_next;
            pending_reg      <= pending_next;
            ctl_cfg_reg      <= ctl_cfg_next;
            expect_cfg_reg   <= expect_cfg_next;
            expect_param_reg <= expect_param_next;
            route_reg        <= route_next;
            wrote_reg        <= wrote_next;
            queued_reg       <= queued_next;
            read_reg         <= read_next;
            dropped_reg      <= dropped_next;
        end
    end

endmodule

// ----- rtl/core/ps2_keyboard_controller_top.sv -----
// ----------------------------------------------------------------------------
// ps2_keyboard_controller_top
// 8042-style PS/2 keyboard controller with a tagged output byte FIFO.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    command, port, data
//   result   out  valid/ready    read_data, flags, three 32-bit counters
//   cfg      in   valid/ready    index, wdata (port addresses)
//
// Each word passes the input register, then decode and the FIFO/state update
// land in the result register. A new word is accepted every cycle unless the
// result stalls; the state update is a single pass.
// Reset clears all control state and the FIFO; addresses return to 0x60/0x64.
// A stalled result register holds the input register, which then stops input.
// ----------------------------------------------------------------------------
module ps2_keyboard_controller_top
    import ps2kc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ps2kc_item_if.sink    item,
    ps2kc_result_if.source result,
    ps2kc_cfg_if.sink     cfg
);

    logic              stage_valid_reg, stage_valid_next;
    item_t             stage_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic [PORT_W-1:0] data_addr_reg;
    logic [PORT_W-1:0] status_addr_reg;

    logic       advance;
    logic       fire;
    logic       take;
    fifo_op_t   fop;
    fifo_stat_t fstat;
    result_t    res;

    // Handshake control
    assign advance    = !out_valid_reg || result.ready;
    assign fire       = stage_valid_reg && advance;
    assign item.ready = !stage_valid_reg || advance;
    assign take       = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        stage_valid_next = take ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);
        out_valid_next   = fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold input word and result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.command <= item.command;
            stage_reg.port    <= item.port;
            stage_reg.data    <= item.data;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    // Port address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_addr_reg   <= DATA_PORT_RST;
            status_addr_reg <= STATUS_PORT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_DATA_PORT:   data_addr_reg   <= cfg.wdata;
                REG_STATUS_PORT: status_addr_reg <= cfg.wdata;
                default: ;
            endcase
        end
    end

    ps2kc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (fire),
        .op    (fop),
        .stat  (fstat)
    );

    ps2kc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (stage_reg),
        .data_addr   (data_addr_reg),
        .status_addr (status_addr_reg),
        .fstat       (fstat),
        .fop         (fop),
        .res         (res)
    );

    // Drive the result channel
    assign result.valid             = out_valid_reg;
    assign result.read_data         = out_reg.read_data;
    assign result.access_ok         = out_reg.access_ok;
    assign result.accepted          = out_reg.accepted;
    assign result.irq_pulse         = out_reg.irq_pulse;
    assign result.aux_flag          = out_reg.aux_flag;
    assign result.byte_pending      = out_reg.byte_pending;
    assign result.guest_initialized = out_reg.guest_initialized;
    assign result.queued_total      = out_reg.queued_total;
    assign result.read_total        = out_reg.read_total;
    assign result.dropped_total     = out_reg.dropped_total;

endmodule
